// ===== sv/wrsd_pkg.sv =====
`timescale 1ns / 1ps

package wrsd_pkg;

   // Known-run table
   localparam int KNOWN_DEPTH = 2048;
   localparam int KNOWN_AW    = $clog2(KNOWN_DEPTH);
   localparam int KNOWN_CW    = $clog2(KNOWN_DEPTH + 1);

   // Run buffer
   localparam int BUF_BYTES   = 8192;
   localparam int CNT_W       = 14;
   localparam int MIN_TRACKED = 16;

   // Field widths
   localparam int ADDR_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 32;
   localparam int SLOT_W      = 11;
   localparam int OUTCOME_W   = 3;
   localparam int SEEN_W      = 32;
   localparam int KIND_W      = 2;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 112;

   localparam logic [ADDR_W-1:0] CHR_LIMIT = 16'h2000;
   localparam logic [CRC_W-1:0]  CRC_POLY  = 32'hEDB88320;
   localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [ADDR_W-1:0] STEP_WIDE = 16'd32;
   localparam logic [ADDR_W-1:0] STEP_ONE  = 16'd1;

   typedef logic [KIND_W-1:0]    req_kind_type;
   localparam req_kind_type REQ_ADDR_SET   = 2'd0;
   localparam req_kind_type REQ_DATA_WRITE = 2'd1;
   localparam req_kind_type REQ_FRAME_END  = 2'd2;

   typedef logic [OUTCOME_W-1:0] outcome_type;
   localparam outcome_type OUT_TOO_SHORT = 3'd0;
   localparam outcome_type OUT_KNOWN     = 3'd1;
   localparam outcome_type OUT_ADDED     = 3'd2;
   localparam outcome_type OUT_NO_DUMP   = 3'd3;
   localparam outcome_type OUT_FULL      = 3'd4;

   typedef struct packed {
      logic [CRC_W-1:0]  crc;
      logic [CNT_W-1:0]  len;
      logic [ADDR_W-1:0] start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Reflected CRC-32, one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/wrsd_ram.sv =====
`timescale 1ns / 1ps

module wrsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/write_run_segmenter_dedup.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  event kind, address, byte, stride bit
// rsp      out        rsp_tvalid/rsp_tready  closed run: start, length, CRC, slot, count
// csr      in         csr_valid/csr_ready    dump_enable
//
// An event that closes no run passes only the accept and evaluate states.
// Closing a run adds the output state; a run of 16 bytes or more first scans the
// known table through the shared compare unit, one entry a cycle, before output.
// The single result register lets a new event enter while the last result waits;
// a close stalls only while that register is still full.
// Synchronous reset clears all control state; the table needs no clearing pass.

module write_run_segmenter_dedup (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wrsd_pkg::REQ_DATA_W-1:0]    req_tdata,  // addr, data, stride32, zero fill
   input  logic [wrsd_pkg::KIND_W-1:0]        req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wrsd_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // run_start, run_length, run_crc,
                                                          // asset_slot, runs_seen, zero fill
   output logic [wrsd_pkg::OUTCOME_W-1:0]     rsp_tuser,  // outcome
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data
);
   import wrsd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;

   localparam int RSP_USED = ADDR_W + CNT_W + CRC_W + SLOT_W + SEEN_W;

   logic [2:0]          state_ff, state_in;
   logic                dump_enable_ff;

   req_kind_type        kind_ff;
   logic [ADDR_W-1:0]   in_addr_ff;
   logic [BYTE_W-1:0]   in_data_ff;
   logic                in_stride_ff;

   logic                run_open_ff, run_open_in;
   logic [ADDR_W-1:0]   start_ff, start_in;
   logic [ADDR_W-1:0]   expect_ff, expect_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                step32_ff, step32_in;
   logic [CRC_W-1:0]    crc_ff, crc_in;
   logic [KNOWN_CW-1:0] known_count_ff, known_count_in;
   logic [SEEN_W-1:0]   runs_ff, runs_in;

   logic [KNOWN_CW-1:0] scan_ff, scan_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [KNOWN_CW-1:0] cmp_idx_ff, cmp_idx_in;
   outcome_type         outcome_ff, outcome_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   outcome_type         rsp_outcome_ff;

   logic                accept, out_free, need_close, apply, closing, hit;
   logic [CRC_W-1:0]    crc_final;
   entry_type           cur_entry, rd_entry;
   logic                wr_en;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign closing    = (state_ff == S_EMIT);

   assign crc_final = ~crc_ff;
   assign cur_entry = {crc_final, count_ff, start_ff};

   assign need_close = run_open_ff && (count_ff != '0) &&
                       ((kind_ff == REQ_ADDR_SET) || (kind_ff == REQ_FRAME_END) ||
                        ((kind_ff == REQ_DATA_WRITE) && (in_addr_ff != expect_ff)));

   assign hit   = cmp_valid_ff && (rd_entry == cur_entry);
   assign apply = ((state_ff == S_EVAL) && !need_close) || ((state_ff == S_EMIT) && out_free);

   wrsd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KNOWN_DEPTH)
   ) u_known (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (known_count_ff[KNOWN_AW-1:0]),
      .wr_data (cur_entry),
      .rd_addr (scan_ff[KNOWN_AW-1:0]),
      .rd_data (rd_entry)
   );

   // Sequencer and shared table compare
   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      outcome_in     = outcome_ff;
      slot_in        = slot_ff;
      known_count_in = known_count_ff;
      runs_in        = runs_ff;
      wr_en          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!need_close) begin
               state_in = S_IDLE;
            end else begin
               if (runs_ff != '1) begin
                  runs_in = runs_ff + 1'b1;
               end
               scan_in = '0;
               if (count_ff >= CNT_W'(MIN_TRACKED)) begin
                  state_in = S_SEARCH;
               end else begin
                  outcome_in = OUT_TOO_SHORT;
                  slot_in    = '0;
                  state_in   = S_EMIT;
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               outcome_in = OUT_KNOWN;
               slot_in    = SLOT_W'(cmp_idx_ff);
               state_in   = S_EMIT;
            end else if (scan_ff < known_count_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff;
               scan_in      = scan_ff + 1'b1;
            end else begin
               state_in = S_EMIT;
               slot_in  = '0;
               if (!dump_enable_ff) begin
                  outcome_in = OUT_NO_DUMP;
               end else if (known_count_ff >= KNOWN_CW'(KNOWN_DEPTH)) begin
                  outcome_in = OUT_FULL;
               end else begin
                  wr_en          = 1'b1;
                  outcome_in     = OUT_ADDED;
                  slot_in        = SLOT_W'(known_count_ff);
                  known_count_in = known_count_ff + 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Run state update for the accepted event, after any close
   always_comb begin
      run_open_in = run_open_ff;
      start_in    = start_ff;
      expect_in   = expect_ff;
      count_in    = count_ff;
      step32_in   = step32_ff;
      crc_in      = crc_ff;
      if (apply) begin
         if (closing) begin
            count_in = '0;
            crc_in   = CRC_INIT;
         end
         case (kind_ff)
            REQ_ADDR_SET: begin
               if (in_addr_ff < CHR_LIMIT) begin
                  run_open_in = 1'b1;
                  start_in    = in_addr_ff;
                  expect_in   = in_addr_ff;
                  count_in    = '0;
                  crc_in      = CRC_INIT;
                  step32_in   = in_stride_ff;
               end else begin
                  run_open_in = 1'b0;
               end
            end
            REQ_DATA_WRITE: begin
               if (!run_open_ff || closing) begin
                  run_open_in = 1'b1;
                  start_in    = in_addr_ff;
                  count_in    = '0;
                  crc_in      = CRC_INIT;
                  step32_in   = in_stride_ff;
               end
               // past the buffer size, drop the byte but keep advancing
               if (count_in < CNT_W'(BUF_BYTES)) begin
                  crc_in   = crc_byte(crc_in, in_data_ff);
                  count_in = count_in + 1'b1;
               end
               expect_in = in_addr_ff + (step32_in ? STEP_WIDE : STEP_ONE);
            end
            REQ_FRAME_END: begin
               run_open_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         dump_enable_ff <= 1'b0;
         run_open_ff    <= 1'b0;
         start_ff       <= '0;
         expect_ff      <= '0;
         count_ff       <= '0;
         step32_ff      <= 1'b0;
         crc_ff         <= CRC_INIT;
         known_count_ff <= '0;
         runs_ff        <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         if (csr_valid && csr_ready) begin
            dump_enable_ff <= csr_data;
         end
         run_open_ff    <= run_open_in;
         start_ff       <= start_in;
         expect_ff      <= expect_in;
         count_ff       <= count_in;
         step32_ff      <= step32_in;
         crc_ff         <= crc_in;
         known_count_ff <= known_count_in;
         runs_ff        <= runs_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      outcome_ff <= outcome_in;
      slot_ff    <= slot_in;
      if (accept) begin
         kind_ff      <= req_tuser;
         in_addr_ff   <= req_tdata[ADDR_W-1:0];
         in_data_ff   <= req_tdata[ADDR_W +: BYTE_W];
         in_stride_ff <= req_tdata[ADDR_W + BYTE_W];
      end
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_data_ff    <= {{(RSP_DATA_W-RSP_USED){1'b0}}, runs_ff, slot_ff,
                            crc_final, count_ff, start_ff};
         rsp_outcome_ff <= outcome_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_outcome_ff;

   a_known_bound: assert property (@(posedge clock) disable iff (reset)
      known_count_ff <= KNOWN_CW'(KNOWN_DEPTH))
      else $error("known table count beyond depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUF_BYTES))
      else $error("stored byte count beyond buffer size");

   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !run_open_ff |-> (count_ff == '0))
      else $error("bytes held with no open run");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (known_count_ff == $past(known_count_ff) + 1'b1) && (state_ff == S_EMIT))
      else $error("table add did not advance the count");

endmodule

// ===== bench/write_run_segmenter_dedup_test.sv =====
`timescale 1ns / 1ps

module write_run_segmenter_dedup_test;
   import wrsd_pkg::*;

   localparam req_kind_type REQ_UNUSED = 2'd3;
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [CNT_W-1:0]  len;
      logic [CRC_W-1:0]  crc;
      outcome_type       outcome;
      logic [SLOT_W-1:0] slot;
      logic [SEEN_W-1:0] seen;
   } run_report_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [OUTCOME_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data = 1'b0;

   // Predictor state
   logic run_live;
   logic [ADDR_W-1:0] run_origin;
   logic [ADDR_W-1:0] next_addr;
   int byte_cnt;
   logic [CRC_W-1:0] crc_acc;
   logic wide_step;
   logic dump_on;
   int known_cnt;
   logic [SEEN_W-1:0] runs_closed;
   logic [ADDR_W-1:0] tbl_start [KNOWN_DEPTH];
   logic [CNT_W-1:0] tbl_len [KNOWN_DEPTH];
   logic [CRC_W-1:0] tbl_crc [KNOWN_DEPTH];

   run_report_type pending_runs [$];

   // Runs worth replaying to hit the known path
   logic [ADDR_W-1:0] lib_start [$];
   logic lib_s32 [$];
   int lib_len [$];
   logic [31:0] lib_seed [$];
   logic [31:0] anchor_seed;

   bit sender_idle_en = 1'b1;
   bit sink_idle_en = 1'b1;
   int hold_request = 0;
   int mismatches = 0;
   int events_sent = 0;
   int runs_checked = 0;
   int outcome_tally [5] = '{default: 0};

   write_run_segmenter_dedup dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Reflected CRC-32, folding one data bit per step
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = acc;
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[0] ^ b[i]) r = (r >> 1) ^ 32'hEDB88320;
         else r = r >> 1;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] fill_byte(input logic [31:0] seed, input int idx);
      logic [31:0] h;
      h = seed ^ (idx * 32'h9E3779B1);
      h = h ^ (h >> 15);
      h = h * 32'h2C1B3C6D;
      return h[31:24];
   endfunction

   task automatic open_run(input logic [ADDR_W-1:0] a, input logic s);
      run_live = 1'b1;
      run_origin = a;
      next_addr = a;
      byte_cnt = 0;
      crc_acc = CRC_INIT;
      wide_step = s;
   endtask

   task automatic close_run();
      run_report_type want;
      logic [CRC_W-1:0] fin;
      bit found;
      fin = ~crc_acc;
      found = 1'b0;
      if (runs_closed != '1) runs_closed++;
      want.start = run_origin;
      want.len = CNT_W'(byte_cnt);
      want.crc = fin;
      want.outcome = OUT_TOO_SHORT;
      want.slot = '0;
      want.seen = runs_closed;
      if (byte_cnt >= MIN_TRACKED) begin
         for (int i = 0; i < known_cnt; i++) begin
            if (tbl_start[i] == run_origin && tbl_len[i] == want.len && tbl_crc[i] == fin) begin
               found = 1'b1;
               want.slot = SLOT_W'(i);
               break;
            end
         end
         if (found) want.outcome = OUT_KNOWN;
         else if (!dump_on) want.outcome = OUT_NO_DUMP;
         else if (known_cnt >= KNOWN_DEPTH) want.outcome = OUT_FULL;
         else begin
            tbl_start[known_cnt] = run_origin;
            tbl_len[known_cnt] = want.len;
            tbl_crc[known_cnt] = fin;
            want.slot = SLOT_W'(known_cnt);
            want.outcome = OUT_ADDED;
            known_cnt++;
         end
      end
      pending_runs.push_back(want);
      byte_cnt = 0;
      crc_acc = CRC_INIT;
   endtask

   task automatic track_event(input req_kind_type kind, input logic [ADDR_W-1:0] a,
                              input logic [BYTE_W-1:0] d, input logic s);
      case (kind)
         REQ_ADDR_SET: begin
            if (run_live && byte_cnt != 0) close_run();
            if (a < CHR_LIMIT) open_run(a, s);
            else run_live = 1'b0;
         end
         REQ_DATA_WRITE: begin
            if (!run_live) open_run(a, s);
            if (a != next_addr && byte_cnt != 0) begin
               close_run();
               open_run(a, s);
            end
            // past the buffer limit only the address keeps moving
            if (byte_cnt < BUF_BYTES) begin
               crc_acc = crc_fold(crc_acc, d);
               byte_cnt++;
            end
            next_addr = a + (wide_step ? STEP_WIDE : STEP_ONE);
         end
         REQ_FRAME_END: begin
            if (run_live && byte_cnt != 0) close_run();
            run_live = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic send_event(input req_kind_type kind, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] d, input logic s);
      int gap;
      gap = 0;
      if (sender_idle_en) while ($urandom_range(99) < 15) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, s, d, a};
      do @(posedge clock); while (!req_tready);
      track_event(kind, a, d, s);
      if (kind != REQ_UNUSED) events_sent++;
   endtask

   task automatic send_run(input logic [ADDR_W-1:0] start, input logic s, input int len,
                           input logic [31:0] seed);
      logic [ADDR_W-1:0] a;
      a = start;
      for (int i = 0; i < len; i++) begin
         send_event(REQ_DATA_WRITE, a, fill_byte(seed, i), s);
         a = a + (s ? STEP_WIDE : STEP_ONE);
      end
   endtask

   task automatic drain();
      int n;
      req_tvalid <= 1'b0;
      n = 0;
      while (pending_runs.size() != 0 && n < 50000) begin
         @(posedge clock);
         n++;
      end
      if (pending_runs.size() != 0) begin
         note_mismatch($sformatf("%0d expected runs never arrived", pending_runs.size()));
         pending_runs.delete();
      end
      // an event that closes nothing may still be in flight
      repeat (known_cnt + 10) @(posedge clock);
   endtask

   task automatic write_dump(input logic v);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dump_on = v;
   endtask

   task automatic check_run(input run_report_type got);
      run_report_type want;
      if (pending_runs.size() == 0) begin
         note_mismatch($sformatf("unexpected run start=%h len=%0d", got.start, got.len));
         return;
      end
      want = pending_runs.pop_front();
      runs_checked++;
      if (want.outcome <= OUT_FULL) outcome_tally[want.outcome]++;
      if (got.start !== want.start)
         note_mismatch($sformatf("start %h, want %h", got.start, want.start));
      if (got.len !== want.len)
         note_mismatch($sformatf("length %0d, want %0d (start %h)", got.len, want.len,
                                 want.start));
      if (got.crc !== want.crc)
         note_mismatch($sformatf("crc %h, want %h (start %h)", got.crc, want.crc, want.start));
      if (got.outcome !== want.outcome)
         note_mismatch($sformatf("outcome %0d, want %0d (start %h)", got.outcome,
                                 want.outcome, want.start));
      if (got.slot !== want.slot)
         note_mismatch($sformatf("slot %0d, want %0d (start %h)", got.slot, want.slot,
                                 want.start));
      if (got.seen !== want.seen)
         note_mismatch($sformatf("run count %0d, want %0d", got.seen, want.seen));
   endtask

   initial begin : rsp_sink
      int hold;
      run_report_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.start = rsp_tdata[15:0];
            got.len = rsp_tdata[29:16];
            got.crc = rsp_tdata[61:30];
            got.slot = rsp_tdata[72:62];
            got.seen = rsp_tdata[104:73];
            got.outcome = rsp_tuser;
            check_run(got);
         end
         if (hold_request != 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         if (hold != 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (sink_idle_en) rsp_tready <= ($urandom_range(99) >= 15);
         else rsp_tready <= 1'b1;
      end
   end

   task automatic edge_case_test();
      send_event(REQ_DATA_WRITE, 16'h0000, 8'h00, 1'b0);  // no run open yet
      send_event(REQ_DATA_WRITE, 16'h0001, 8'hFF, 1'b0);
      send_event(REQ_ADDR_SET, 16'h1FFF, 8'h00, 1'b1);
      send_event(REQ_DATA_WRITE, 16'h0100, 8'hA5, 1'b1);  // empty run keeps its set start
      send_event(REQ_DATA_WRITE, 16'h0120, 8'h5A, 1'b0);  // stride stays latched
      send_event(REQ_FRAME_END, 16'hFFFF, 8'hFF, 1'b1);
      send_event(REQ_FRAME_END, 16'h0000, 8'h00, 1'b0);
      send_event(REQ_ADDR_SET, 16'h2000, 8'h00, 1'b0);    // at limit: leaves nothing open
      send_event(REQ_DATA_WRITE, 16'hFFFF, 8'h81, 1'b0);
      send_event(REQ_DATA_WRITE, 16'h0000, 8'h7E, 1'b1);  // wraps at step 1
      send_event(REQ_ADDR_SET, 16'hFFFF, 8'hFF, 1'b1);
      send_event(REQ_UNUSED, 16'($urandom), 8'($urandom), 1'b1);
      send_event(REQ_DATA_WRITE, 16'hFFE0, 8'h3C, 1'b1);
      send_event(REQ_DATA_WRITE, 16'h0000, 8'hC3, 1'b1);  // wraps at step 32
      send_event(REQ_DATA_WRITE, 16'h0005, 8'h11, 1'b0);  // gap closes and reopens
      send_event(REQ_ADDR_SET, 16'h0003, 8'h00, 1'b0);
      send_event(REQ_ADDR_SET, 16'h0007, 8'h00, 1'b1);    // empty run: no transfer
      send_event(REQ_UNUSED, 16'h0000, 8'h00, 1'b0);
      send_event(REQ_FRAME_END, 16'h1234, 8'h56, 1'b0);
   endtask

   task automatic dedup_test();
      anchor_seed = $urandom;
      send_event(REQ_ADDR_SET, 16'h0040, 8'h00, 1'b0);
      send_run(16'h0040, 1'b0, MIN_TRACKED, anchor_seed);
      send_event(REQ_ADDR_SET, 16'h0400, 8'h00, 1'b1);
      send_run(16'h0400, 1'b1, MIN_TRACKED - 1, $urandom);
      send_event(REQ_FRAME_END, 16'h0000, 8'h00, 1'b0);
      drain();
      write_dump(1'b1);
      repeat (2) begin
         send_event(REQ_ADDR_SET, 16'h0040, 8'h00, 1'b0);
         send_run(16'h0040, 1'b0, MIN_TRACKED, anchor_seed);
      end
      send_event(REQ_ADDR_SET, 16'h0040, 8'h00, 1'b1);
      send_run(16'h0040, 1'b1, MIN_TRACKED, anchor_seed);
      send_event(REQ_ADDR_SET, 16'h1000, 8'h00, 1'b1);
      send_run(16'h1000, 1'b1, MIN_TRACKED + 1, $urandom);
      send_event(REQ_FRAME_END, 16'h0000, 8'h00, 1'b0);
   endtask

   task automatic random_traffic(input int count);
      int stop_at, r, len, pick;
      logic [ADDR_W-1:0] start;
      logic s;
      logic [31:0] seed;
      stop_at = events_sent + count;
      while (events_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 55 || (r < 75 && lib_start.size() == 0)) begin
            start = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16'h1FFF));
            s = 1'($urandom_range(1));
            seed = $urandom;
            pick = $urandom_range(9);
            len = (pick < 5) ? $urandom_range(1, 15) :
                  (pick < 9) ? $urandom_range(16, 40) : $urandom_range(41, 120);
            send_event(REQ_ADDR_SET, start, 8'($urandom), s);
            send_run(start, s, len, seed);
            if (len >= MIN_TRACKED) begin
               if (lib_start.size() >= 64) begin
                  pick = $urandom_range(63);
                  lib_start[pick] = start;
                  lib_s32[pick] = s;
                  lib_len[pick] = len;
                  lib_seed[pick] = seed;
               end else begin
                  lib_start.push_back(start);
                  lib_s32.push_back(s);
                  lib_len.push_back(len);
                  lib_seed.push_back(seed);
               end
            end
         end else if (r < 75) begin
            pick = $urandom_range(lib_start.size() - 1);
            // occasionally skip the address set and let the gap start the run
            if ($urandom_range(3) != 0)
               send_event(REQ_ADDR_SET, lib_start[pick], 8'($urandom), lib_s32[pick]);
            send_run(lib_start[pick], lib_s32[pick], lib_len[pick], lib_seed[pick]);
         end else if (r < 82) begin
            send_event(REQ_FRAME_END, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
         end else if (r < 88) begin
            send_event(REQ_ADDR_SET, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
         end else if (r < 95) begin
            send_event(REQ_DATA_WRITE, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
         end else begin
            send_event(REQ_UNUSED, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic backpressure_test();
      logic [ADDR_W-1:0] a;
      hold_request = 400;
      repeat (30) begin
         a = 16'($urandom);
         send_event(REQ_DATA_WRITE, a, 8'($urandom), 1'b0);
         send_event(REQ_DATA_WRITE, a + 16'd1, 8'($urandom), 1'b0);
         send_event(REQ_FRAME_END, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      run_live = 1'b0;
      run_origin = '0;
      next_addr = '0;
      byte_cnt = 0;
      crc_acc = CRC_INIT;
      wide_step = 1'b0;
      dump_on = 1'b0;
      known_cnt = 0;
      runs_closed = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_dump(1'b0);

      edge_case_test();
      dedup_test();
      drain();
      write_dump(1'b0);
      random_traffic(250);
      drain();
      write_dump(1'b1);
      sender_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      random_traffic(250);
      sender_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      backpressure_test();
      random_traffic(250);
      drain();

      $display("Covered %0d events: edge cases, duplicate lookups, random runs, a long stall",
               events_sent);
      $display("%0d runs checked, outcomes %0d/%0d/%0d/%0d/%0d", runs_checked,
               outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
               outcome_tally[4]);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/wrsd_pkg.sv
sv/wrsd_ram.sv
sv/write_run_segmenter_dedup.sv
bench/write_run_segmenter_dedup_test.sv
